@@ rtl/core/hufd_pkg.sv @@
// Shared types and constants for the Huffman tree decoder.
package hufd_pkg;

	localparam int IDX_W     = 9;
	localparam int SYM_W     = 8;
	localparam int BYTE_W    = 8;
	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam int BIT_CNT_W = 3;

	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_DECODE  = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_LIMIT = 1'b1;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

	typedef struct packed {
		logic             leaf;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [SYM_W-1:0] sym;
	} node_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [IDX_W-1:0]  node_index;
		logic              node_is_leaf;
		logic [IDX_W-1:0]  left_child;
		logic [IDX_W-1:0]  right_child;
		logic [SYM_W-1:0]  node_symbol;
		logic [BYTE_W-1:0] data_byte;
	} req_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} rsp_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] child;
		logic             leaf_hit;
		logic             emit;
		logic [SYM_W-1:0] symbol;
	} step_res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_ROOT,
		S_RD_WALK,
		S_BIT,
		S_LAST,
		S_FLUSH
	} state_t;

endpackage

@@ rtl/core/huffman_tree_decoder.sv @@
// Top level of the Huffman tree decoder: sequencer, walk state and output register.
//
//  Channel  Direction  Handshake              Word
//  req      in         req_valid/req_ready    req_data (load node, decode byte, restart)
//  rsp      out        rsp_valid/rsp_ready    rsp_data (symbol, last)
//  cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Load and restart words are taken in idle, which they do not leave. A decode word keeps
// ready low after acceptance until its walk is done: two tree reads to fetch the root and
// the current node, one step per code bit, one leaf check and one flush of the final
// symbol; a full output register can hold the bit, check and flush steps. The single read
// port of the tree memory sets this, since each bit needs the node read by the bit before.
// A full output register holds the walk until the next symbol can move out.
// Reset clears the walk to node 0, the count and both registers; tree contents are not cleared.
module huffman_tree_decoder #(
	parameter int NODE_COUNT = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  hufd_pkg::req_item_t             req_data,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output hufd_pkg::rsp_item_t             rsp_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hufd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hufd_pkg::CNT_W-1:0]      cfg_data
);

	hufd_pkg::state_t                  state_q, state_d;
	logic [hufd_pkg::IDX_W-1:0]        root_node_q;
	logic [hufd_pkg::CNT_W-1:0]        symbol_limit_q;
	logic [hufd_pkg::IDX_W-1:0]        walk_q;
	logic [hufd_pkg::CNT_W-1:0]        count_q;
	logic [hufd_pkg::BYTE_W-1:0]       byte_q;
	logic [hufd_pkg::BIT_CNT_W-1:0]    bit_cnt_q;
	logic                              first_q;
	hufd_pkg::node_t                   root_nd_q;
	logic                              pend_valid_q;
	logic [hufd_pkg::SYM_W-1:0]        pend_sym_q;
	logic                              out_valid_q;
	hufd_pkg::rsp_item_t               out_q;

	logic                              req_acc;
	logic                              cfg_acc;
	logic                              slot_free;
	logic                              stall;
	logic                              step_check;
	logic                              go;
	logic                              push;
	logic                              push_last;
	logic                              ram_we;
	logic                              ram_re;
	logic [hufd_pkg::IDX_W-1:0]        ram_ridx;
	hufd_pkg::node_t                   ram_wnode;
	hufd_pkg::node_t                   ram_rnode;
	hufd_pkg::step_res_t               step;

	assign req_ready = (state_q == hufd_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign req_acc   = req_valid && req_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;
	assign slot_free = !out_valid_q || rsp_ready;

	assign ram_we          = req_acc && (req_data.req_type == hufd_pkg::REQ_LOAD);
	assign ram_wnode.leaf  = req_data.node_is_leaf;
	assign ram_wnode.left  = req_data.left_child;
	assign ram_wnode.right = req_data.right_child;
	assign ram_wnode.sym   = req_data.node_symbol;

	hufd_tree_ram #(
		.NODE_COUNT(NODE_COUNT)
	) u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ram_we),
		.widx  (req_data.node_index),
		.wnode (ram_wnode),
		.re    (ram_re),
		.ridx  (ram_ridx),
		.rnode (ram_rnode)
	);

	assign step_check = (state_q == hufd_pkg::S_LAST) ||
		((state_q == hufd_pkg::S_BIT) && !first_q);

	hufd_step_unit u_step (
		.rd_node  (ram_rnode),
		.root_node(root_nd_q),
		.check    (step_check),
		.code_bit (byte_q[hufd_pkg::BYTE_W-1]),
		.count    (count_q),
		.limit    (symbol_limit_q),
		.res      (step)
	);

	// A new symbol needs the pending one moved out first.
	assign stall = step.emit && pend_valid_q && !slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hufd_pkg::S_IDLE: begin
				if (req_acc && (req_data.req_type == hufd_pkg::REQ_DECODE)) begin
					state_d = hufd_pkg::S_RD_ROOT;
				end
			end
			hufd_pkg::S_RD_ROOT: state_d = hufd_pkg::S_RD_WALK;
			hufd_pkg::S_RD_WALK: state_d = hufd_pkg::S_BIT;
			hufd_pkg::S_BIT: begin
				if (!stall && (bit_cnt_q == hufd_pkg::LAST_BIT)) begin
					state_d = hufd_pkg::S_LAST;
				end
			end
			hufd_pkg::S_LAST: begin
				if (!stall) begin
					state_d = hufd_pkg::S_FLUSH;
				end
			end
			hufd_pkg::S_FLUSH: begin
				if (!pend_valid_q || slot_free) begin
					state_d = hufd_pkg::S_IDLE;
				end
			end
			default: state_d = hufd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_ridx  = root_node_q;
		go        = 1'b0;
		push      = 1'b0;
		push_last = 1'b0;
		unique case (state_q)
			hufd_pkg::S_IDLE: begin
			end
			hufd_pkg::S_RD_ROOT: begin
				ram_re = 1'b1;
			end
			hufd_pkg::S_RD_WALK: begin
				ram_re   = 1'b1;
				ram_ridx = walk_q;
			end
			hufd_pkg::S_BIT: begin
				if (!stall) begin
					go       = 1'b1;
					ram_re   = 1'b1;
					ram_ridx = step.child;
					push     = step.emit && pend_valid_q;
				end
			end
			hufd_pkg::S_LAST: begin
				if (!stall) begin
					go   = 1'b1;
					push = step.emit && pend_valid_q;
				end
			end
			hufd_pkg::S_FLUSH: begin
				if (pend_valid_q && slot_free) begin
					push      = 1'b1;
					push_last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= hufd_pkg::S_IDLE;
			root_node_q    <= '0;
			symbol_limit_q <= '0;
			walk_q         <= '0;
			count_q        <= '0;
			bit_cnt_q      <= '0;
			first_q        <= 1'b0;
			pend_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_acc) begin
				unique case (cfg_index)
					hufd_pkg::CFG_ROOT_NODE:    root_node_q    <= cfg_data[hufd_pkg::IDX_W-1:0];
					hufd_pkg::CFG_SYMBOL_LIMIT: symbol_limit_q <= cfg_data;
					default: begin
					end
				endcase
			end

			priority if (cfg_acc && (cfg_index == hufd_pkg::CFG_ROOT_NODE)) begin
				walk_q <= cfg_data[hufd_pkg::IDX_W-1:0];
			end else if (req_acc && (req_data.req_type == hufd_pkg::REQ_RESTART)) begin
				walk_q <= root_node_q;
			end else if (go && (state_q == hufd_pkg::S_BIT)) begin
				walk_q <= step.child;
			end else if (go && step.leaf_hit) begin
				walk_q <= root_node_q;
			end else begin
				walk_q <= walk_q;
			end

			if (req_acc && (req_data.req_type == hufd_pkg::REQ_RESTART)) begin
				count_q <= '0;
			end else if (go && step.leaf_hit && (count_q != '1)) begin
				count_q <= count_q + 1'b1;
			end

			if (req_acc) begin
				bit_cnt_q <= '0;
			end else if (go && (state_q == hufd_pkg::S_BIT)) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end

			if (state_q == hufd_pkg::S_RD_WALK) begin
				first_q <= 1'b1;
			end else if (go) begin
				first_q <= 1'b0;
			end

			if (go && step.emit) begin
				pend_valid_q <= 1'b1;
			end else if (push_last) begin
				pend_valid_q <= 1'b0;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			byte_q <= req_data.data_byte;
		end else if (go && (state_q == hufd_pkg::S_BIT)) begin
			byte_q <= {byte_q[hufd_pkg::BYTE_W-2:0], 1'b0};
		end

		if (state_q == hufd_pkg::S_RD_WALK) begin
			root_nd_q <= ram_rnode;
		end

		if (go && step.emit) begin
			pend_sym_q <= step.symbol;
		end

		if (push) begin
			out_q.symbol <= pend_sym_q;
			out_q.last   <= push_last;
		end
	end

	// The held symbol is always flushed before the block takes a new word.
	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hufd_pkg::S_IDLE) |-> !pend_valid_q)
		else $error("pending symbol left over in idle");

	// During a decode the count only moves upward.
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != hufd_pkg::S_IDLE) |=> (count_q >= $past(count_q)))
		else $error("symbol count went down during a decode");

	// A leaf on the final bit returns the walk to the root.
	a_last_leaf_root: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == hufd_pkg::S_LAST) && go && step.leaf_hit) |=> (walk_q == $past(root_node_q)))
		else $error("walk not back at root after final leaf");

	// A decode never pushes while the output register is still full and stalled.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q) |-> rsp_ready)
		else $error("output register overwritten");

endmodule

@@ rtl/core/hufd_tree_ram.sv @@
// Tree node memory: one write port, one registered read port, out-of-range reads give a zero node.
module hufd_tree_ram #(
	parameter int NODE_COUNT = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [hufd_pkg::IDX_W-1:0]  widx,
	input  hufd_pkg::node_t             wnode,
	input  logic                        re,
	input  logic [hufd_pkg::IDX_W-1:0]  ridx,
	output hufd_pkg::node_t             rnode
);

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam logic [hufd_pkg::IDX_W:0] NodeLim = (hufd_pkg::IDX_W + 1)'(NODE_COUNT);

	hufd_pkg::node_t mem [NODE_COUNT];
	hufd_pkg::node_t rdata_q;
	logic            oob_q;
	logic            w_in_range;
	logic            r_in_range;

	assign w_in_range = ({1'b0, widx} < NodeLim);
	assign r_in_range = ({1'b0, ridx} < NodeLim);

	always_ff @(posedge clk) begin
		if (we && w_in_range) begin
			mem[widx[AW-1:0]] <= wnode;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[ridx[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oob_q <= 1'b0;
		end else if (re) begin
			oob_q <= !r_in_range;
		end
	end

	assign rnode = oob_q ? '0 : rdata_q;

endmodule

@@ rtl/core/hufd_step_unit.sv @@
// One walk step: leaf check of the node just read, then child selection by the code bit.
module hufd_step_unit (
	input  hufd_pkg::node_t              rd_node,
	input  hufd_pkg::node_t              root_node,
	input  logic                         check,
	input  logic                         code_bit,
	input  logic [hufd_pkg::CNT_W-1:0]   count,
	input  logic [hufd_pkg::CNT_W-1:0]   limit,
	output hufd_pkg::step_res_t          res
);

	hufd_pkg::node_t cur;
	logic            leaf_hit;

	// A leaf sends the walk back to the root before the next bit is applied.
	assign leaf_hit = check && rd_node.leaf;
	assign cur      = leaf_hit ? root_node : rd_node;

	assign res.leaf_hit = leaf_hit;
	assign res.emit     = leaf_hit && (count < limit);
	assign res.symbol   = rd_node.sym;
	assign res.child    = code_bit ? cur.right : cur.left;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the Huffman tree decoder with a predicting scoreboard.
`timescale 1ns / 100ps

module testbench;

	localparam int NODES = 512;
	localparam int SETTLE_CYCLES = 32;
	localparam int DRAIN_LIMIT = 50000;
	localparam int PHASES = 12;
	localparam int WORDS_PER_PHASE = 18;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Predicts the symbols of every accepted request word and checks them in order.
	class symbol_tracker_t;
		hufd_pkg::node_t                tree [NODES];
		logic [hufd_pkg::IDX_W-1:0]     root;
		logic [hufd_pkg::IDX_W-1:0]     walk;
		logic [hufd_pkg::CNT_W-1:0]     limit;
		logic [hufd_pkg::CNT_W-1:0]     seen;
		hufd_pkg::rsp_item_t            expected_symbols[$];
		int                             errors;

		function new();
			foreach (tree[i])
				tree[i] = '0;
			root = '0;
			walk = '0;
			limit = '0;
			seen = '0;
			errors = 0;
		endfunction

		function void apply_reg(logic [hufd_pkg::CFG_IDX_W-1:0] idx,
			logic [hufd_pkg::CNT_W-1:0] value);
			if (idx == hufd_pkg::CFG_ROOT_NODE) begin
				root = value[hufd_pkg::IDX_W-1:0];
				walk = root;
			end else if (idx == hufd_pkg::CFG_SYMBOL_LIMIT) begin
				limit = value;
			end
		endfunction

		function void note_request(hufd_pkg::req_item_t r);
			hufd_pkg::node_t     cur;
			hufd_pkg::node_t     nxt;
			hufd_pkg::rsp_item_t batch[$];
			hufd_pkg::rsp_item_t one;
			int                  i;
			case (r.req_type)
				hufd_pkg::REQ_LOAD: begin
					tree[r.node_index] = {r.node_is_leaf, r.left_child, r.right_child,
						r.node_symbol};
				end
				hufd_pkg::REQ_RESTART: begin
					walk = root;
					seen = '0;
				end
				hufd_pkg::REQ_DECODE: begin
					for (i = hufd_pkg::BYTE_W - 1; i >= 0; i--) begin
						cur = tree[walk];
						walk = r.data_byte[i] ? cur.right : cur.left;
						nxt = tree[walk];
						if (nxt.leaf) begin
							// A leaf past the limit still counts and restarts the walk.
							if (seen < limit && batch.size() < 8) begin
								one.symbol = nxt.sym;
								one.last = 1'b0;
								batch = {batch, one};
							end
							if (seen != 32'hFFFF_FFFF)
								seen++;
							walk = root;
						end
					end
					if (batch.size() > 0)
						batch[batch.size() - 1].last = 1'b1;
					expected_symbols = {expected_symbols, batch};
				end
				default: begin
				end
			endcase
		endfunction

		function void check_symbol(hufd_pkg::rsp_item_t got);
			hufd_pkg::rsp_item_t want;
			if (expected_symbols.size() == 0) begin
				$display("%0t: symbol %h last %b arrived with nothing expected",
					$time, got.symbol, got.last);
				errors++;
				return;
			end
			want = expected_symbols.pop_front();
			if (got.symbol !== want.symbol) begin
				$display("%0t: symbol mismatch, expected %h, got %h",
					$time, want.symbol, got.symbol);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last flag mismatch, expected %b, got %b",
					$time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           req_valid;
	logic                           req_ready;
	hufd_pkg::req_item_t            req_data;
	logic                           rsp_valid;
	logic                           rsp_ready;
	hufd_pkg::rsp_item_t            rsp_data;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [hufd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [hufd_pkg::CNT_W-1:0]     cfg_data;

	symbol_tracker_t                board;
	int                             send_idle_pct;
	int                             recv_stall_pct;
	bit                             written [NODES];
	logic [hufd_pkg::IDX_W-1:0]     written_q[$];

	huffman_tree_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic hufd_pkg::req_item_t random_item(logic [1:0] kind);
		logic [63:0]         raw;
		hufd_pkg::req_item_t item;
		raw = {$urandom, $urandom};
		item = raw[$bits(hufd_pkg::req_item_t)-1:0];
		item.req_type = kind;
		return item;
	endfunction

	// Valid stays high from one word to the next unless an idle gap is taken.
	task automatic send_request(input hufd_pkg::req_item_t item);
		if (chance(send_idle_pct)) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while (chance(send_idle_pct))
				@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		board.note_request(item);
	endtask

	task automatic load_node(input logic [hufd_pkg::IDX_W-1:0] idx, input logic leaf,
		input logic [hufd_pkg::IDX_W-1:0] lc, input logic [hufd_pkg::IDX_W-1:0] rc,
		input logic [hufd_pkg::SYM_W-1:0] sym);
		hufd_pkg::req_item_t item;
		item = random_item(hufd_pkg::REQ_LOAD);
		item.node_index = idx;
		item.node_is_leaf = leaf;
		item.left_child = lc;
		item.right_child = rc;
		item.node_symbol = sym;
		send_request(item);
		if (!written[idx]) begin
			written[idx] = 1'b1;
			written_q = {written_q, idx};
		end
	endtask

	task automatic send_byte(input logic [hufd_pkg::BYTE_W-1:0] code_bits);
		hufd_pkg::req_item_t item;
		item = random_item(hufd_pkg::REQ_DECODE);
		item.data_byte = code_bits;
		send_request(item);
	endtask

	task automatic write_reg(input logic [hufd_pkg::CFG_IDX_W-1:0] idx,
		input logic [hufd_pkg::CNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.apply_reg(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// A decode word may still be walking after its last symbol, so SETTLE_CYCLES more pass.
	task automatic settle();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		while (board.expected_symbols.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Loads a complete tree on fresh random indices by joining random subtrees pairwise.
	// Leaf children point inside the tree, so no walk ever reaches an unloaded node.
	task automatic grow_tree(input int leaves, output logic [hufd_pkg::IDX_W-1:0] top);
		logic [hufd_pkg::IDX_W-1:0] ids[$];
		logic [hufd_pkg::IDX_W-1:0] open_q[$];
		bit                         taken [NODES];
		logic [hufd_pkg::IDX_W-1:0] idx;
		logic [hufd_pkg::IDX_W-1:0] a;
		logic [hufd_pkg::IDX_W-1:0] b;
		int                         j;
		int                         k;
		while (ids.size() < 2 * leaves - 1) begin
			idx = 9'($urandom_range(NODES - 1));
			if (!taken[idx]) begin
				taken[idx] = 1'b1;
				ids = {ids, idx};
			end
		end
		for (j = 0; j < leaves; j++) begin
			load_node(ids[j], 1'b1, ids[$urandom_range(ids.size() - 1)],
				ids[$urandom_range(ids.size() - 1)], 8'($urandom));
			open_q = {open_q, ids[j]};
		end
		for (j = leaves; j < ids.size(); j++) begin
			k = $urandom_range(open_q.size() - 1);
			a = open_q[k];
			open_q.delete(k);
			k = $urandom_range(open_q.size() - 1);
			b = open_q[k];
			open_q.delete(k);
			load_node(ids[j], 1'b0, a, b, 8'($urandom));
			open_q = {open_q, ids[j]};
		end
		top = ids[ids.size() - 1];
	endtask

	initial begin
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				board.check_symbol(rsp_data);
			rsp_ready <= !chance(recv_stall_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int                         p;
		int                         n;
		int                         k;
		int                         leaves;
		logic [hufd_pkg::IDX_W-1:0] top;
		logic [hufd_pkg::CNT_W-1:0] reg_word;

		board = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Small tree rooted at node 0: codes 0, 10 and 11 for symbols 00, FF and A5.
		load_node(9'd0, 1'b0, 9'd1, 9'd511, 8'h3C);
		load_node(9'd1, 1'b1, 9'd0, 9'd0, 8'h00);
		load_node(9'd511, 1'b0, 9'd2, 9'd3, 8'hC3);
		load_node(9'd2, 1'b1, 9'd511, 9'd511, 8'hFF);
		load_node(9'd3, 1'b1, 9'd1, 9'd2, 8'hA5);
		send_request(random_item(REQ_UNUSED));
		// The limit is still zero after reset, so every leaf is suppressed.
		send_byte(8'h00);
		settle();
		write_reg(hufd_pkg::CFG_SYMBOL_LIMIT, 32'd10);
		send_byte(8'hFF);
		send_request(random_item(hufd_pkg::REQ_RESTART));
		send_byte(8'h00);
		send_byte(8'hB4);
		send_request(random_item(hufd_pkg::REQ_RESTART));
		settle();
		write_reg(hufd_pkg::CFG_SYMBOL_LIMIT, 32'hFFFF_FFFF);
		// A code split across two words, then a restart in the middle of a code.
		send_byte(8'h01);
		send_byte(8'h7F);
		send_request(random_item(hufd_pkg::REQ_RESTART));
		settle();
		write_reg(hufd_pkg::CFG_ROOT_NODE, 32'hFFFF_FFFF);
		send_byte(8'h55);
		settle();
		// A leaf as root: every bit lands on a leaf.
		write_reg(hufd_pkg::CFG_ROOT_NODE, 32'd3);
		send_byte(8'h0F);
		settle();
		write_reg(hufd_pkg::CFG_ROOT_NODE, 32'd0);
		send_byte(8'h80);

		for (p = 0; p < PHASES; p++) begin
			settle();
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 79;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 79;
				end
				default: begin
					send_idle_pct = 17;
					recv_stall_pct = 17;
				end
			endcase
			case (p % 6)
				0: reg_word = 32'hFFFF_FFFF;
				1: reg_word = $urandom_range(40, 3);
				2: reg_word = 32'd0;
				3: reg_word = 32'd1;
				4: reg_word = $urandom;
				default: reg_word = $urandom_range(200, 50);
			endcase
			write_reg(hufd_pkg::CFG_SYMBOL_LIMIT, reg_word);
			leaves = chance(25) ? $urandom_range(40, 13) : $urandom_range(12, 2);
			grow_tree(leaves, top);
			settle();
			reg_word = $urandom;
			reg_word[hufd_pkg::IDX_W-1:0] = top;
			write_reg(hufd_pkg::CFG_ROOT_NODE, reg_word);
			send_request(random_item(hufd_pkg::REQ_RESTART));
			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				k = $urandom_range(99);
				if (k < 74) begin
					send_byte(8'($urandom));
				end else if (k < 81) begin
					send_request(random_item(hufd_pkg::REQ_RESTART));
				end else if (k < 93) begin
					// Rewrite or add a node; its children are always loaded nodes.
					load_node(9'($urandom_range(NODES - 1)), 1'($urandom),
						written_q[$urandom_range(written_q.size() - 1)],
						written_q[$urandom_range(written_q.size() - 1)], 8'($urandom));
				end else begin
					send_request(random_item(REQ_UNUSED));
				end
			end
		end

		settle();
		if (board.expected_symbols.size() != 0) begin
			$display("%0t: %0d expected symbols never arrived, next expected %h last %b",
				$time, board.expected_symbols.size(), board.expected_symbols[0].symbol,
				board.expected_symbols[0].last);
			board.errors++;
		end
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
